// ----- sv/xsdv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsdv_pkg
// Shared types and constants for the date/time lexical validator.
// ----------------------------------------------------------------------------
package xsdv_pkg;

  typedef enum logic [4:0] {
    PH_START    = 5'd0,
    PH_YSIGN    = 5'd1,
    PH_YEAR     = 5'd2,
    PH_MON1     = 5'd3,
    PH_MON2     = 5'd4,
    PH_MDASH    = 5'd5,
    PH_DAY1     = 5'd6,
    PH_DAY2     = 5'd7,
    PH_DATE_END = 5'd8,
    PH_HOUR1    = 5'd9,
    PH_HOUR2    = 5'd10,
    PH_HCOLON   = 5'd11,
    PH_MIN1     = 5'd12,
    PH_MIN2     = 5'd13,
    PH_MCOLON   = 5'd14,
    PH_SEC1     = 5'd15,
    PH_SEC2     = 5'd16,
    PH_TIME_END = 5'd17,
    PH_FRAC1    = 5'd18,
    PH_FRAC     = 5'd19,
    PH_TZ_DONE  = 5'd20,
    PH_TZH1     = 5'd21,
    PH_TZH2     = 5'd22,
    PH_TZCOLON  = 5'd23,
    PH_TZM1     = 5'd24,
    PH_TZM2     = 5'd25
  } phase_e;

  typedef enum logic [1:0] {
    LT_DATE     = 2'd0,
    LT_TIME     = 2'd1,
    LT_DATETIME = 2'd2,
    LT_BAD      = 2'd3
  } lex_type_e;

  typedef enum logic [1:0] {
    ZK_NONE   = 2'd0,
    ZK_UTC    = 2'd1,
    ZK_OFFSET = 2'd2
  } zone_kind_e;

  localparam logic [13:0] YearMax = 14'd9999;
  localparam logic [4:0]  HourMax = 5'd24;
  localparam logic [5:0]  SecMax  = 6'd60;
  localparam logic [3:0]  TzHourMax = 4'd14;
  localparam logic [2:0]  AddrCfgLexType = 3'd0;
  // ceil(2^22 / 25), exact quotient for any year value below 2^17
  localparam logic [17:0] Div25Recip = 18'd167773;

  typedef struct packed {
    logic        valid_res;
    logic [17:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [1:0]  zone_kind;
    logic        zone_negative;
    logic [3:0]  zone_hours;
    logic [5:0]  zone_minutes;
  } res_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_string;
  } chr_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
      4'd2:                                       month_len = 5'd28;
      default:                                    month_len = 5'd0;
    endcase
  endfunction

endpackage

// ----- sv/xsdv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsdv_chr_if / xsdv_res_if
// Valid/ready channels for characters and results.
// ----------------------------------------------------------------------------
interface xsdv_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       end_of_string;
  modport source (output valid, char_code, has_char, end_of_string, input ready);
  modport sink (input valid, char_code, has_char, end_of_string, output ready);
endinterface

interface xsdv_res_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [17:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [1:0]  zone_kind;
  logic        zone_negative;
  logic [3:0]  zone_hours;
  logic [5:0]  zone_minutes;
  modport source (output valid, valid_res, year, month, day, hour, minute, second,
                  zone_kind, zone_negative, zone_hours, zone_minutes, input ready);
  modport sink (input valid, valid_res, year, month, day, hour, minute, second,
                zone_kind, zone_negative, zone_hours, zone_minutes, output ready);
endinterface

// ----- sv/xsd_datetime_lexical_validator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsd_datetime_lexical_validator
// Streaming lexical check of date, time and dateTime strings.
//
// Usage:
//   chr: one character per transaction (char_code, has_char, end_of_string).
//   res: one transaction per string, issued for the end_of_string item:
//        valid_res and the parsed fields, all zero when invalid.
//   APB register 0 (lexical_type, reset 2): 0 date, 1 time, 2 dateTime.
//   Write it only between strings.
// Timing:
//   A character is registered on entry and parsed in the next cycle; the
//   result is then registered in the result buffer. One character per
//   cycle is sustained while chr ready is high; the parse state update is
//   the single-cycle loop. A two-entry result buffer keeps the input
//   moving while res is stalled; chr ready drops only when it could overflow.
// Reset:
//   Clears the parse state, the pipeline and the buffer; mode returns to 2.
// ----------------------------------------------------------------------------
module xsd_datetime_lexical_validator
  import xsdv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  xsdv_chr_if.sink    chr,
  xsdv_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] lex_q;
  chr_t       in_q;
  logic       in_vld_q;
  res_t       pres;
  res_t       buf_q [2];
  logic [1:0] cnt_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic       push, pop, take;
  logic [1:0] in_flight;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrCfgLexType) ? {30'd0, lex_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_q <= LT_DATETIME;
    end else if (psel && penable && pwrite && paddr == AddrCfgLexType) begin
      lex_q <= pwdata[1:0];
    end
  end

  // space for buffered results plus one in the input register
  assign in_flight = cnt_q + 2'(in_vld_q && in_q.end_of_string);
  assign chr.ready = (in_flight < 2'd2) || pop;
  assign take      = chr.valid && chr.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= '{char_code: chr.char_code, has_char: chr.has_char,
                end_of_string: chr.end_of_string};
    end
  end

  xsdv_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_vld_q),
    .chr_i      (in_q),
    .lex_type_i (lex_q),
    .res_o      (pres)
  );

  assign push = in_vld_q && in_q.end_of_string;
  assign pop  = res.valid && res.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wr_ptr_q <= 1'b0; rd_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= pres;
  end

  assign res.valid         = (cnt_q != 2'd0);
  assign res.valid_res     = buf_q[rd_ptr_q].valid_res;
  assign res.year          = buf_q[rd_ptr_q].year;
  assign res.month         = buf_q[rd_ptr_q].month;
  assign res.day           = buf_q[rd_ptr_q].day;
  assign res.hour          = buf_q[rd_ptr_q].hour;
  assign res.minute        = buf_q[rd_ptr_q].minute;
  assign res.second        = buf_q[rd_ptr_q].second;
  assign res.zone_kind     = buf_q[rd_ptr_q].zone_kind;
  assign res.zone_negative = buf_q[rd_ptr_q].zone_negative;
  assign res.zone_hours    = buf_q[rd_ptr_q].zone_hours;
  assign res.zone_minutes  = buf_q[rd_ptr_q].zone_minutes;

endmodule

// ----- sv/xsdv_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsdv_parse
// Per-string parse state: one character step per cycle while step_i is high, result on end mark.
// ----------------------------------------------------------------------------
module xsdv_parse
  import xsdv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  chr_t       chr_i,
  input  logic [1:0] lex_type_i,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        fail_q, fail_d;
  logic        yneg_q, yneg_d;
  logic [16:0] yacc_q, yacc_d;
  logic        yfrz_q, yfrz_d;
  logic [3:0]  mon_q, mon_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hr_q, hr_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic        zs_q, zs_d;
  logic [3:0]  zh_q, zh_d;
  logic [5:0]  zm_q, zm_d;
  logic [1:0]  zseen_q, zseen_d;

  logic [7:0]  c;
  logic        dig;
  logic [3:0]  d;
  logic [7:0]  v_mon, v_day, v_hr, v_min, v_sec, v_zh, v_zm;
  logic [20:0] ymul;
  logic [4:0]  lim;
  logic        leap;
  logic [35:0] yrec;
  logic [11:0] yq25;
  logic [16:0] y25x;
  logic        ydiv25;
  logic        ok;
  res_t        res;

  assign c   = chr_i.char_code;
  assign dig = (c >= 8'h30) && (c <= 8'h39);
  assign d   = dig ? c[3:0] : 4'd0;
  assign v_mon = 8'(mon_q) * 8'd10 + 8'(d);
  assign v_day = 8'(day_q) * 8'd10 + 8'(d);
  assign v_hr  = 8'(hr_q) * 8'd10 + 8'(d);
  assign v_min = 8'(min_q) * 8'd10 + 8'(d);
  assign v_sec = 8'(sec_q) * 8'd10 + 8'(d);
  assign v_zh  = 8'(zh_q) * 8'd10 + 8'(d);
  assign v_zm  = 8'(zm_q) * 8'd10 + 8'(d);
  assign ymul  = 21'(yacc_q) * 21'd10 + 21'(d);

  // divisibility by 25 through a reciprocal multiply and back-multiply
  assign yrec   = 36'(yacc_q) * 36'(Div25Recip);
  assign yq25   = yrec[33:22];
  assign y25x   = {1'b0, yq25, 4'd0} + {2'b0, yq25, 3'd0} + {5'd0, yq25};
  assign ydiv25 = (y25x == yacc_q);
  assign leap = (yacc_q[1:0] == 2'b00) && (!ydiv25 || (yacc_q[3:0] == 4'd0));
  assign lim  = (mon_q == 4'd2 && leap) ? 5'd29 : month_len(mon_q);

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; fail_d = fail_q; yneg_d = yneg_q;
    yacc_d = yacc_q; yfrz_d = yfrz_q; mon_d = mon_q; day_d = day_q;
    hr_d = hr_q; min_d = min_q; sec_d = sec_q; zs_d = zs_q; zh_d = zh_q;
    zm_d = zm_q; zseen_d = zseen_q;
    if (chr_i.has_char && !fail_q) begin
      case (phase_q)
        PH_START: begin
          if (lex_type_i == LT_TIME) begin
            if (dig) begin hr_d = 5'(d); phase_d = PH_HOUR2; end else fail_d = 1'b1;
          end else if (lex_type_i == LT_DATE || lex_type_i == LT_DATETIME) begin
            if (c == "+" || c == "-") begin
              yneg_d = (c == "-"); phase_d = PH_YSIGN;
            end else if (dig) begin
              yacc_d = ymul[16:0]; yfrz_d = ymul > 21'(YearMax);
              cnt_d = cnt_q + 4'd1; phase_d = PH_YEAR;
            end else fail_d = 1'b1;
          end else fail_d = 1'b1;
        end
        PH_YSIGN, PH_YEAR: begin
          if (dig) begin
            if (!yfrz_q) begin
              yacc_d = ymul[16:0]; yfrz_d = ymul > 21'(YearMax);
            end
            if (cnt_q < 4'd15) cnt_d = cnt_q + 4'd1;
            phase_d = PH_YEAR;
          end else if (phase_q == PH_YEAR && c == "-" && cnt_q >= 4'd4) begin
            phase_d = PH_MON1;
          end else fail_d = 1'b1;
        end
        PH_MON1: if (dig) begin mon_d = d; phase_d = PH_MON2; end else fail_d = 1'b1;
        PH_MON2: begin
          if (dig && v_mon >= 8'd1 && v_mon <= 8'd12) begin
            mon_d = v_mon[3:0]; phase_d = PH_MDASH;
          end else fail_d = 1'b1;
        end
        PH_MDASH: if (c == "-") phase_d = PH_DAY1; else fail_d = 1'b1;
        PH_DAY1: if (dig) begin day_d = 5'(d); phase_d = PH_DAY2; end else fail_d = 1'b1;
        PH_DAY2: begin
          if (dig && v_day >= 8'd1 && v_day <= 8'(lim)) begin
            day_d = v_day[4:0]; phase_d = PH_DATE_END;
          end else fail_d = 1'b1;
        end
        PH_DATE_END: begin
          if (lex_type_i == LT_DATE) begin
            if (c == "Z" || c == "z") begin zseen_d = 2'd1; phase_d = PH_TZ_DONE; end
            else if (c == "+" || c == "-") begin zs_d = (c == "-"); phase_d = PH_TZH1; end
            else fail_d = 1'b1;
          end else if (lex_type_i == LT_DATETIME && c == "T") phase_d = PH_HOUR1;
          else fail_d = 1'b1;
        end
        PH_HOUR1: if (dig) begin hr_d = 5'(d); phase_d = PH_HOUR2; end else fail_d = 1'b1;
        PH_HOUR2: begin
          if (dig && v_hr <= 8'(HourMax)) begin
            hr_d = v_hr[4:0]; phase_d = PH_HCOLON;
          end else fail_d = 1'b1;
        end
        PH_HCOLON: if (c == ":") phase_d = PH_MIN1; else fail_d = 1'b1;
        PH_MIN1: if (dig) begin min_d = 6'(d); phase_d = PH_MIN2; end else fail_d = 1'b1;
        PH_MIN2: begin
          if (dig && v_min < 8'd60) begin min_d = v_min[5:0]; phase_d = PH_MCOLON; end
          else fail_d = 1'b1;
        end
        PH_MCOLON: if (c == ":") phase_d = PH_SEC1; else fail_d = 1'b1;
        PH_SEC1: if (dig) begin sec_d = 6'(d); phase_d = PH_SEC2; end else fail_d = 1'b1;
        PH_SEC2: begin
          if (dig && v_sec <= 8'(SecMax) &&
              !(hr_q == HourMax && (min_q != 6'd0 || v_sec != 8'd0))) begin
            sec_d = v_sec[5:0]; phase_d = PH_TIME_END;
          end else fail_d = 1'b1;
        end
        PH_TIME_END, PH_FRAC: begin
          if (phase_q == PH_TIME_END && c == ".") phase_d = PH_FRAC1;
          else if (phase_q == PH_FRAC && dig) phase_d = PH_FRAC;
          else if (c == "Z" || c == "z") begin zseen_d = 2'd1; phase_d = PH_TZ_DONE; end
          else if (c == "+" || c == "-") begin zs_d = (c == "-"); phase_d = PH_TZH1; end
          else fail_d = 1'b1;
        end
        PH_FRAC1: if (dig) phase_d = PH_FRAC; else fail_d = 1'b1;
        PH_TZH1: if (dig) begin zh_d = d; phase_d = PH_TZH2; end else fail_d = 1'b1;
        PH_TZH2: begin
          if (dig && v_zh <= 8'(TzHourMax)) begin zh_d = v_zh[3:0]; phase_d = PH_TZCOLON; end
          else fail_d = 1'b1;
        end
        PH_TZCOLON: if (c == ":") phase_d = PH_TZM1; else fail_d = 1'b1;
        PH_TZM1: if (dig) begin zm_d = 6'(d); phase_d = PH_TZM2; end else fail_d = 1'b1;
        PH_TZM2: begin
          if (dig && v_zm < 8'd60 && !(zh_q == TzHourMax && v_zm != 8'd0)) begin
            zm_d = v_zm[5:0]; zseen_d = 2'd2; phase_d = PH_TZ_DONE;
          end else fail_d = 1'b1;
        end
        default: fail_d = 1'b1;
      endcase
    end
  end

  // acceptance on the post-character state
  always_comb begin
    res = '0;
    ok  = 1'b0;
    if (!fail_d) begin
      case (phase_d)
        PH_DATE_END:         ok = (lex_type_i == LT_DATE);
        PH_TIME_END, PH_FRAC: ok = (lex_type_i == LT_TIME) || (lex_type_i == LT_DATETIME);
        PH_TZ_DONE:          ok = (lex_type_i != LT_BAD);
        default:             ok = 1'b0;
      endcase
    end
    if (ok) begin
      res.valid_res = 1'b1;
      res.year   = yneg_d ? 18'(-$signed({1'b0, yacc_d})) : {1'b0, yacc_d};
      res.month  = mon_d;
      res.day    = day_d;
      res.hour   = hr_d;
      res.minute = min_d;
      res.second = sec_d;
      if (zseen_d == 2'd1 || (zseen_d == 2'd2 && zh_d == 4'd0 && zm_d == 6'd0)) begin
        res.zone_kind = ZK_UTC;
      end else if (zseen_d == 2'd2) begin
        res.zone_kind     = ZK_OFFSET;
        res.zone_negative = zs_d;
        res.zone_hours    = zh_d;
        res.zone_minutes  = zm_d;
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START; cnt_q <= '0; fail_q <= 1'b0; yneg_q <= 1'b0;
      yacc_q <= '0; yfrz_q <= 1'b0; mon_q <= '0; day_q <= '0; hr_q <= '0;
      min_q <= '0; sec_q <= '0; zs_q <= 1'b0; zh_q <= '0; zm_q <= '0; zseen_q <= '0;
    end else if (step_i) begin
      if (chr_i.end_of_string) begin
        phase_q <= PH_START; cnt_q <= '0; fail_q <= 1'b0; yneg_q <= 1'b0;
        yacc_q <= '0; yfrz_q <= 1'b0; mon_q <= '0; day_q <= '0; hr_q <= '0;
        min_q <= '0; sec_q <= '0; zs_q <= 1'b0; zh_q <= '0; zm_q <= '0; zseen_q <= '0;
      end else begin
        phase_q <= phase_d; cnt_q <= cnt_d; fail_q <= fail_d; yneg_q <= yneg_d;
        yacc_q <= yacc_d; yfrz_q <= yfrz_d; mon_q <= mon_d; day_q <= day_d;
        hr_q <= hr_d; min_q <= min_d; sec_q <= sec_d; zs_q <= zs_d; zh_q <= zh_d;
        zm_q <= zm_d; zseen_q <= zseen_d;
      end
    end
  end

endmodule

// ----- sv/xsdv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xsdv_checker
// Port-level checks on result transactions and on pready, bound to the top level.
// ----------------------------------------------------------------------------
module xsdv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_valid_res,
  input logic [17:0] res_year,
  input logic [3:0]  res_month,
  input logic [1:0]  res_zone_kind,
  input logic        res_zone_negative,
  input logic        pready
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_valid_res |-> res_year == 18'd0 && res_month == 4'd0 &&
      res_zone_kind == 2'd0)
    else $error("invalid result carries fields");

  a_zone_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_zone_kind != 2'd2 |-> !res_zone_negative)
    else $error("sign without offset");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_valid_res |-> res_month <= 4'd12)
    else $error("month out of range");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind xsd_datetime_lexical_validator xsdv_checker u_xsdv_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_valid_res     (res.valid_res),
  .res_year          (res.year),
  .res_month         (res.month),
  .res_zone_kind     (res.zone_kind),
  .res_zone_negative (res.zone_negative),
  .pready            (pready)
);
